FILE: rtl/iask_pkg.sv
// shared types and constants for the imu accel scalar kalman block
`timescale 1ns / 1ps

package iask_pkg;

  localparam int EST_W      = 24;
  localparam int RATE_W     = 16;
  localparam int COV_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 8'd1;

  localparam logic [CFG_DATA_W-1:0] PROCESS_NOISE_RST     = 31'd107374;
  localparam logic [CFG_DATA_W-1:0] MEASUREMENT_NOISE_RST = 31'd10737418;

  localparam logic [COV_W-1:0] ONE_Q30 = 32'h4000_0000;

  localparam logic [1:0] SEL_FORWARD  = 2'd0;
  localparam logic [1:0] SEL_LATERAL  = 2'd1;
  localparam logic [1:0] SEL_VERTICAL = 2'd2;
  localparam logic [1:0] SEL_COV      = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DINIT,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic       load;
    logic       pred;
    logic       div_init;
    logic       div_step;
    logic       mul;
    logic       acc;
    logic       write;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

FILE: rtl/imu_accel_scalar_kalman.sv
// top level of the imu accel scalar kalman filter
`timescale 1ns / 1ps

// Takes one IMU sample per transaction, remaps the axes (forward = accel z,
// lateral = -accel x, vertical = -accel y, roll = gyro z, pitch = -gyro x,
// yaw = -gyro y, negation saturating) and smooths each acceleration with a
// scalar random-walk Kalman filter whose covariance and gain are shared by
// the three axes. Estimates carry 8 fractional bits; Q and R are Q30 values
// written through the cfg port (index 0 process noise, index 1 measurement
// noise); the user must write them only while the block is idle, which the
// block itself does not enforce. The first sample seeds the estimates.
// A sample is loaded, predicted, divided by the restoring gain divider (one
// quotient bit per cycle), multiplied and accumulated for each axis and the
// covariance, then written to the result register once any earlier result
// has been taken; only then is a new sample accepted. A finished result waits
// in the output register while the next sample is accepted.

module imu_accel_scalar_kalman
  import iask_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_in_x,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_in_y,
  input  logic signed [SAMPLE_BITS-1:0] in_accel_in_z,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_in_x,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_in_y,
  input  logic signed [SAMPLE_BITS-1:0] in_gyro_in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [EST_W-1:0]       out_filtered_forward,
  output logic signed [EST_W-1:0]       out_filtered_lateral,
  output logic signed [EST_W-1:0]       out_filtered_vertical,
  output logic signed [RATE_W-1:0]      out_rate_roll,
  output logic signed [RATE_W-1:0]      out_rate_pitch,
  output logic signed [RATE_W-1:0]      out_rate_yaw,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  iask_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  iask_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .accel_x       (in_accel_in_x),
    .accel_y       (in_accel_in_y),
    .accel_z       (in_accel_in_z),
    .gyro_x        (in_gyro_in_x),
    .gyro_y        (in_gyro_in_y),
    .gyro_z        (in_gyro_in_z),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .filt_forward  (out_filtered_forward),
    .filt_lateral  (out_filtered_lateral),
    .filt_vertical (out_filtered_vertical),
    .rate_roll     (out_rate_roll),
    .rate_pitch    (out_rate_pitch),
    .rate_yaw      (out_rate_yaw)
  );

endmodule

FILE: rtl/iask_ctrl.sv
// sequencing state machine for the kalman update
`timescale 1ns / 1ps

module iask_ctrl
  import iask_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  sel_r, sel_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= SEL_FORWARD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd.pred  = 1'b1;
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          sel_nxt   = SEL_FORWARD;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sel_r == SEL_COV) begin
          state_nxt = ST_OUT;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.write     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_out_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && !out_ready) |=> (state_r == ST_OUT))
    else $error("result overwritten while output stalled");

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PRED))
    else $error("accepted transaction did not start processing");

  a_valid_from_out : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("output valid raised outside result write");

endmodule

FILE: rtl/iask_datapath.sv
// remap, serial gain divider, shared multiplier and filter state
`timescale 1ns / 1ps

module iask_datapath
  import iask_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic signed [SAMPLE_BITS-1:0] gyro_x,
  input  logic signed [SAMPLE_BITS-1:0] gyro_y,
  input  logic signed [SAMPLE_BITS-1:0] gyro_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  output logic signed [EST_W-1:0]       filt_forward,
  output logic signed [EST_W-1:0]       filt_lateral,
  output logic signed [EST_W-1:0]       filt_vertical,
  output logic signed [RATE_W-1:0]      rate_roll,
  output logic signed [RATE_W-1:0]      rate_pitch,
  output logic signed [RATE_W-1:0]      rate_yaw
);

  localparam int G     = GAIN_FRAC_BITS;
  localparam int SB    = SAMPLE_BITS;
  localparam int ZW    = ((SB + 8) > EST_W) ? (SB + 8) : EST_W;
  localparam int RW    = (SB > RATE_W) ? SB : RATE_W;
  localparam int CNT_W = $clog2(G + 1);
  localparam int PW    = 35 + G;

  localparam logic signed [ZW:0] Z_MAX = (ZW+1)'(8388607);
  localparam logic signed [ZW:0] Z_MIN = -(ZW+1)'(8388608);
  localparam logic signed [RW:0] R_MAX = (RW+1)'(32767);
  localparam logic signed [RW:0] R_MIN = -(RW+1)'(32768);
  localparam logic signed [26:0] E_MAX = 27'sd8388607;
  localparam logic signed [26:0] E_MIN = -27'sd8388608;
  localparam logic [SB-1:0]      S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0]      S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [G:0]         UNITY = {1'b1, {G{1'b0}}};

  function automatic logic signed [SB-1:0] neg_sat(input logic signed [SB-1:0] v);
    logic signed [SB-1:0] r;
    if (v == S_MIN) begin
      r = S_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  function automatic logic signed [EST_W-1:0] to_meas(input logic signed [SB-1:0] v);
    logic signed [ZW:0] w;
    logic signed [EST_W-1:0] r;
    w = (ZW+1)'(v) <<< 8;
    if (w > Z_MAX) begin
      r = 24'sh7FFFFF;
    end else if (w < Z_MIN) begin
      r = 24'sh800000;
    end else begin
      r = w[EST_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [RATE_W-1:0] to_rate(input logic signed [SB-1:0] v);
    logic signed [RW:0] w;
    logic signed [RATE_W-1:0] r;
    w = (RW+1)'(v);
    if (w > R_MAX) begin
      r = 16'sh7FFF;
    end else if (w < R_MIN) begin
      r = 16'sh8000;
    end else begin
      r = w[RATE_W-1:0];
    end
    return r;
  endfunction

  logic [CFG_DATA_W-1:0]    q_r, rn_r;
  logic                     seeded_r;
  logic [COV_W-1:0]         cov_r;
  logic signed [EST_W-1:0]  est_r [3];
  logic signed [EST_W-1:0]  z_r [3];
  logic signed [RATE_W-1:0] rroll_r, rpitch_r, ryaw_r;
  logic [COV_W-1:0]         ppred_r;
  logic [COV_W:0]           den_r;
  logic [COV_W+1:0]         rem_r;
  logic [G:0]               quot_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [EST_W-1:0]  ofwd_r, olat_r, overt_r;
  logic signed [RATE_W-1:0] oroll_r, opitch_r, oyaw_r;

  logic [COV_W-1:0]         p_base;
  logic [COV_W:0]           p_sum;
  logic [COV_W-1:0]         ppred_nxt;
  logic [COV_W+1:0]         den_ext;
  logic                     ge;
  logic [COV_W+1:0]         rem_sub;
  logic [G:0]               gain_w;
  logic signed [EST_W:0]    diff_w;
  logic signed [32:0]       mul_a;
  logic signed [G+1:0]      mul_b;
  logic signed [PW-1:0]     prod_nxt;
  logic signed [PW-1:0]     prod_sh;
  logic signed [26:0]       est_sum;
  logic signed [EST_W-1:0]  est_new;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= PROCESS_NOISE_RST;
      rn_r <= MEASUREMENT_NOISE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PROCESS_NOISE) begin
        q_r <= cfg_data;
      end else if (cfg_index == CFG_MEASUREMENT_NOISE) begin
        rn_r <= cfg_data;
      end
    end
  end

  // predicted covariance, seeded on the first transaction
  always_comb begin
    p_base    = seeded_r ? cov_r : ONE_Q30;
    p_sum     = {1'b0, p_base} + {2'b0, q_r};
    ppred_nxt = p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    den_ext = {1'b0, den_r};
    ge      = (rem_r >= den_ext);
    rem_sub = ge ? (rem_r - den_ext) : rem_r;
    gain_w  = (quot_r > UNITY) ? UNITY : quot_r;
  end

  assign sts.div_done = (cnt_r == CNT_W'(G));

  // shared multiplier operands
  always_comb begin
    diff_w = '0;
    if (cmd.sel == SEL_COV) begin
      mul_a = {1'b0, ppred_r};
      mul_b = {1'b0, UNITY - gain_w};
    end else begin
      diff_w = (EST_W+1)'(z_r[cmd.sel]) - (EST_W+1)'(est_r[cmd.sel]);
      mul_a  = 33'(diff_w);
      mul_b  = {1'b0, gain_w};
    end
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    prod_sh = prod_r >>> G;
    est_sum = 27'(est_r[cmd.sel]) + prod_sh[26:0];
    if (est_sum > E_MAX) begin
      est_new = 24'sh7FFFFF;
    end else if (est_sum < E_MIN) begin
      est_new = 24'sh800000;
    end else begin
      est_new = est_sum[EST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r <= 1'b0;
    end else if (cmd.pred) begin
      seeded_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z_r[SEL_FORWARD]  <= to_meas(accel_z);
      z_r[SEL_LATERAL]  <= to_meas(neg_sat(accel_x));
      z_r[SEL_VERTICAL] <= to_meas(neg_sat(accel_y));
      rroll_r           <= to_rate(gyro_z);
      rpitch_r          <= to_rate(neg_sat(gyro_x));
      ryaw_r            <= to_rate(neg_sat(gyro_y));
    end
    if (cmd.pred) begin
      ppred_r <= ppred_nxt;
      if (!seeded_r) begin
        est_r <= z_r;
      end
    end
    if (cmd.div_init) begin
      den_r  <= {1'b0, ppred_r} + {2'b0, rn_r};
      rem_r  <= {2'b0, ppred_r};
      quot_r <= '0;
      cnt_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= {rem_sub[COV_W:0], 1'b0};
      quot_r <= {quot_r[G-1:0], ge};
      cnt_r  <= cnt_r + CNT_W'(1);
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc) begin
      if (cmd.sel == SEL_COV) begin
        cov_r <= prod_r[G +: COV_W];
      end else begin
        est_r[cmd.sel] <= est_new;
      end
    end
    if (cmd.write) begin
      ofwd_r   <= est_r[SEL_FORWARD];
      olat_r   <= est_r[SEL_LATERAL];
      overt_r  <= est_r[SEL_VERTICAL];
      oroll_r  <= rroll_r;
      opitch_r <= rpitch_r;
      oyaw_r   <= ryaw_r;
    end
  end

  assign filt_forward  = ofwd_r;
  assign filt_lateral  = olat_r;
  assign filt_vertical = overt_r;
  assign rate_roll     = oroll_r;
  assign rate_pitch    = opitch_r;
  assign rate_yaw      = oyaw_r;

  a_gain_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> (gain_w <= UNITY))
    else $error("gain above unity at multiply");

  a_cov_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.acc) && $past(cmd.sel) == SEL_COV) |-> (cov_r <= ppred_r))
    else $error("updated covariance above prediction");

endmodule

FILE: tb/iask_estimate_checker.sv
// checker for the imu accel scalar kalman block: predicts and compares every result
`timescale 1ns / 1ps

module iask_estimate_checker
  import iask_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [15:0]       accel_x,
  input  logic signed [15:0]       accel_y,
  input  logic signed [15:0]       accel_z,
  input  logic signed [15:0]       gyro_x,
  input  logic signed [15:0]       gyro_y,
  input  logic signed [15:0]       gyro_z,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [EST_W-1:0]  forward,
  input  logic signed [EST_W-1:0]  lateral,
  input  logic signed [EST_W-1:0]  vertical,
  input  logic signed [RATE_W-1:0] roll,
  input  logic signed [RATE_W-1:0] pitch,
  input  logic signed [RATE_W-1:0] yaw,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       checked
);

  localparam longint EST_HI   = 64'sd8388607;
  localparam longint EST_LO   = -64'sd8388608;
  localparam longint RATE_HI  = 64'sd32767;
  localparam longint COV_SAT  = 64'sh0000_0000_FFFF_FFFF;
  localparam longint UNITY    = 64'sd1 << GAIN_FRAC_BITS;

  typedef struct packed {
    logic signed [EST_W-1:0]  fwd;
    logic signed [EST_W-1:0]  lat;
    logic signed [EST_W-1:0]  vert;
    logic signed [RATE_W-1:0] roll;
    logic signed [RATE_W-1:0] pitch;
    logic signed [RATE_W-1:0] yaw;
  } filt_result_t;

  filt_result_t estimates_due[$];

  bit     seeded;
  longint est[3];
  longint cov;
  longint q_noise;
  longint r_noise;

  initial begin
    errors  = 0;
    checked = 0;
    pending = 0;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint negate_sat(input longint v);
    return (-v > RATE_HI) ? RATE_HI : -v;
  endfunction

  function automatic filt_result_t kalman_step(input longint ax, input longint ay,
                                               input longint az, input longint gx,
                                               input longint gy, input longint gz);
    longint       meas[3];
    longint       p_pred;
    longint       den;
    longint       k;
    longint       upd;
    filt_result_t r;
    meas[0] = clip(az * 256, EST_LO, EST_HI);
    meas[1] = clip(negate_sat(ax) * 256, EST_LO, EST_HI);
    meas[2] = clip(negate_sat(ay) * 256, EST_LO, EST_HI);
    if (!seeded) begin
      for (int i = 0; i < 3; i++) est[i] = meas[i];
      cov    = ONE_Q30;
      seeded = 1'b1;
    end
    p_pred = cov + q_noise;
    if (p_pred > COV_SAT) p_pred = COV_SAT;
    den = p_pred + r_noise;
    if (den == 0) k = UNITY;
    else k = (p_pred << GAIN_FRAC_BITS) / den;
    if (k > UNITY) k = UNITY;
    for (int i = 0; i < 3; i++) begin
      upd    = est[i] + ((k * (meas[i] - est[i])) >>> GAIN_FRAC_BITS);
      est[i] = clip(upd, EST_LO, EST_HI);
    end
    cov     = ((UNITY - k) * p_pred) >> GAIN_FRAC_BITS;
    r.fwd   = EST_W'(est[0]);
    r.lat   = EST_W'(est[1]);
    r.vert  = EST_W'(est[2]);
    r.roll  = RATE_W'(gz);
    r.pitch = RATE_W'(negate_sat(gx));
    r.yaw   = RATE_W'(negate_sat(gy));
    return r;
  endfunction

  task automatic check_field(input string label, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t %s: expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    filt_result_t want;
    if (!rst_n) begin
      seeded  = 1'b0;
      est     = '{0, 0, 0};
      cov     = ONE_Q30;
      q_noise = PROCESS_NOISE_RST;
      r_noise = MEASUREMENT_NOISE_RST;
      estimates_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PROCESS_NOISE) q_noise = cfg_data;
        else if (cfg_index == CFG_MEASUREMENT_NOISE) r_noise = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (estimates_due.size() == 0) begin
          errors++;
          $display("%0t result transaction with none expected: expected nothing, actual %0d",
                   $time, forward);
        end else begin
          want = estimates_due.pop_front();
          checked++;
          check_field("filtered_forward", want.fwd, forward);
          check_field("filtered_lateral", want.lat, lateral);
          check_field("filtered_vertical", want.vert, vertical);
          check_field("rate_roll", want.roll, roll);
          check_field("rate_pitch", want.pitch, pitch);
          check_field("rate_yaw", want.yaw, yaw);
        end
      end
      if (in_valid && in_ready)
        estimates_due.push_back(kalman_step(accel_x, accel_y, accel_z,
                                            gyro_x, gyro_y, gyro_z));
    end
    pending <= estimates_due.size();
  end

endmodule

FILE: tb/tb.sv
// testbench top for the imu accel scalar kalman block: stimulus, noise settings and verdict
`timescale 1ns / 1ps

module tb;
  import iask_pkg::*;

  localparam int     SAMPLE_BITS    = 16;
  localparam int     GAIN_FRAC_BITS = 16;
  localparam int     DRAIN_CYCLES   = GAIN_FRAC_BITS + 14;
  localparam int     CYCLE_LIMIT    = 600000;
  localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED = 8'd2;
  localparam logic [CFG_DATA_W-1:0] NOISE_MAX  = 31'h7FFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] NOISE_ONE  = 31'h4000_0000;
  localparam logic [CFG_DATA_W-1:0] NOISE_ZERO = 31'd0;
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = -16'sd32768;
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = 16'sd32767;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_BITS-1:0] in_accel_in_x = '0;
  logic signed [SAMPLE_BITS-1:0] in_accel_in_y = '0;
  logic signed [SAMPLE_BITS-1:0] in_accel_in_z = '0;
  logic signed [SAMPLE_BITS-1:0] in_gyro_in_x = '0;
  logic signed [SAMPLE_BITS-1:0] in_gyro_in_y = '0;
  logic signed [SAMPLE_BITS-1:0] in_gyro_in_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [EST_W-1:0]  out_filtered_forward;
  logic signed [EST_W-1:0]  out_filtered_lateral;
  logic signed [EST_W-1:0]  out_filtered_vertical;
  logic signed [RATE_W-1:0] out_rate_roll;
  logic signed [RATE_W-1:0] out_rate_pitch;
  logic signed [RATE_W-1:0] out_rate_yaw;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic calm = 1'b0;
  int   errors;
  int   pending;
  int   checked;
  int   cycle_count = 0;
  int   samples_sent = 0;
  int   settings_used = 1;
  logic signed [SAMPLE_BITS-1:0] drift[3] = '{0, 0, 0};

  imu_accel_scalar_kalman #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_accel_in_x        (in_accel_in_x),
    .in_accel_in_y        (in_accel_in_y),
    .in_accel_in_z        (in_accel_in_z),
    .in_gyro_in_x         (in_gyro_in_x),
    .in_gyro_in_y         (in_gyro_in_y),
    .in_gyro_in_z         (in_gyro_in_z),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_filtered_forward (out_filtered_forward),
    .out_filtered_lateral (out_filtered_lateral),
    .out_filtered_vertical(out_filtered_vertical),
    .out_rate_roll        (out_rate_roll),
    .out_rate_pitch       (out_rate_pitch),
    .out_rate_yaw         (out_rate_yaw),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  iask_estimate_checker #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) i_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .accel_x  (in_accel_in_x),
    .accel_y  (in_accel_in_y),
    .accel_z  (in_accel_in_z),
    .gyro_x   (in_gyro_in_x),
    .gyro_y   (in_gyro_in_y),
    .gyro_z   (in_gyro_in_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .forward  (out_filtered_forward),
    .lateral  (out_filtered_lateral),
    .vertical (out_filtered_vertical),
    .roll     (out_rate_roll),
    .pitch    (out_rate_pitch),
    .yaw      (out_rate_yaw),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 33);
  end

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] ax,
                             input logic signed [SAMPLE_BITS-1:0] ay,
                             input logic signed [SAMPLE_BITS-1:0] az,
                             input logic signed [SAMPLE_BITS-1:0] gx,
                             input logic signed [SAMPLE_BITS-1:0] gy,
                             input logic signed [SAMPLE_BITS-1:0] gz);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_accel_in_x <= ax;
    in_accel_in_y <= ay;
    in_accel_in_z <= az;
    in_gyro_in_x  <= gx;
    in_gyro_in_y  <= gy;
    in_gyro_in_z  <= gz;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] any_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: any_sample = SMIN;
      1: any_sample = SMAX;
      2: any_sample = SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      default: any_sample = SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // mostly slowly drifting accelerations with noise, the rest arbitrary
  task automatic random_samples(input int count);
    logic signed [SAMPLE_BITS-1:0] a[3];
    int t;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 3; i++) begin
        if ($urandom_range(0, 99) < 65) begin
          t        = drift[i] + (int'($urandom_range(0, 400)) - 200);
          drift[i] = t[SAMPLE_BITS-1:0];
          t        = drift[i] + (int'($urandom_range(0, 60)) - 30);
          a[i]     = t[SAMPLE_BITS-1:0];
        end else begin
          a[i] = any_sample();
        end
      end
      send_sample(a[0], a[1], a[2], any_sample(), any_sample(), any_sample());
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // let the filter drain, then optionally write the unused index and load new noise values
  task automatic change_setting(input logic [CFG_DATA_W-1:0] q, input logic [CFG_DATA_W-1:0] r,
                                input bit poke_unused);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (poke_unused) write_reg(CFG_UNUSED, NOISE_MAX);
    write_reg(CFG_PROCESS_NOISE, q);
    write_reg(CFG_MEASUREMENT_NOISE, r);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // seeding sample, then field extremes and bit patterns
    send_sample(16'sd1000, -16'sd2000, 16'sd16384, 16'sd5, -16'sd6, 16'sd7);
    send_sample(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
    send_sample(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_sample(SMIN, SMAX, 16'sd0, SMIN, SMAX, SMIN);
    send_sample(SMAX, SMIN, SMIN, SMAX, SMIN, SMAX);
    send_sample(16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_sample(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    send_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_sample(SMIN, SMIN, SMAX, SMIN, SMIN, SMAX);
    send_sample(SMAX, SMAX, SMIN, SMAX, SMAX, SMIN);
    random_samples(180);

    // zero noise: unity gain, then a zero gain denominator
    change_setting(NOISE_ZERO, NOISE_ZERO, 1'b1);
    send_sample(16'sd300, -16'sd300, 16'sd300, 16'sd1, 16'sd2, 16'sd3);
    send_sample(SMIN, SMAX, SMIN, SMIN, SMIN, SMIN);
    send_sample(SMAX, SMIN, SMAX, SMAX, SMAX, SMAX);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    random_samples(80);

    change_setting(NOISE_MAX, NOISE_MAX, 1'b0);
    random_samples(120);
    change_setting(NOISE_ONE, NOISE_ZERO, 1'b0);
    random_samples(80);
    change_setting(NOISE_ZERO, NOISE_ONE, 1'b0);
    random_samples(120);

    calm <= 1'b1;
    change_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(0, 32'h0100_0000)), 1'b0);
    random_samples(150);
    calm <= 1'b0;

    change_setting(PROCESS_NOISE_RST, MEASUREMENT_NOISE_RST, 1'b0);
    random_samples(200);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d imu samples under %0d noise settings, %0d filtered results compared",
             samples_sent, settings_used, checked);
    $display("included seeding, zero and full-scale noise, zero gain denominator, saturating negation");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/iask_pkg.sv
rtl/iask_ctrl.sv
rtl/iask_datapath.sv
rtl/imu_accel_scalar_kalman.sv
tb/iask_estimate_checker.sv
tb/tb.sv
